### design/csvp_pkg.sv
// Shared types and constants for the four-field CSV sample parser.
// No dependencies; used by csvp_front, csvp_back and the top level.
`timescale 1ns / 1ps
`default_nettype none
package csvp_pkg;

   localparam int unsigned MAX_LINE         = 21;
   localparam int unsigned DIGITS_PER_FIELD = 4;
   localparam int unsigned NUM_FIELDS       = 4;

   localparam logic [2:0]  MAX_COMMAS   = 3'd4;
   localparam logic [11:0] OFFSET_RESET = 12'd2048;

   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam int unsigned AC_W       = 15;
   localparam int unsigned DC_W       = 14;

   typedef logic [DC_W-1:0] field_type;

   typedef enum logic [1:0] {
      KIND_OTHER = 2'd0,
      KIND_DIGIT = 2'd1,
      KIND_COMMA = 2'd2,
      KIND_EOL   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] digit;
   } token_type;

   typedef struct packed {
      logic signed [AC_W-1:0] ac_red;
      field_type              dc_red;
      logic signed [AC_W-1:0] ac_infrared;
      field_type              dc_infrared;
   } record_type;

endpackage
`default_nettype wire

### design/csvp_front.sv
// Front end: classifies each received character and queues the token.
// Depends on csvp_pkg; feeds csvp_back through a two-entry queue.
`timescale 1ns / 1ps
`default_nettype none
module csvp_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [7:0]           in_ch,
   output logic                      tok_valid,
   input  wire logic                 tok_ready,
   output csvp_pkg::token_type       tok
);

   csvp_pkg::token_type cls;
   csvp_pkg::token_type q_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                push, pop;

   always_comb begin
      cls.digit = 4'd0;
      if ((in_ch == csvp_pkg::CH_CR) || (in_ch == csvp_pkg::CH_LF)) begin
         cls.kind = csvp_pkg::KIND_EOL;
      end else if (in_ch == csvp_pkg::CH_COMMA) begin
         cls.kind = csvp_pkg::KIND_COMMA;
      end else if ((in_ch >= csvp_pkg::CH_ZERO) && (in_ch <= csvp_pkg::CH_NINE)) begin
         cls.kind  = csvp_pkg::KIND_DIGIT;
         cls.digit = in_ch[3:0];
      end else begin
         cls.kind = csvp_pkg::KIND_OTHER;
      end
   end

   assign in_ready  = (count_ff != 2'd2);
   assign tok_valid = (count_ff != 2'd0);
   assign tok       = q_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = tok_valid && tok_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule
`default_nettype wire

### design/csvp_back.sv
// Back end: line parser state, digit accumulation and the result register.
// Depends on csvp_pkg; takes tokens from csvp_front.
`timescale 1ns / 1ps
`default_nettype none
module csvp_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 tok_valid,
   output logic                      tok_ready,
   input  wire csvp_pkg::token_type  tok,
   input  wire logic [11:0]          ac_offset,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output csvp_pkg::record_type      out_rec
);

   localparam logic [4:0] MAX_LEN = 5'(csvp_pkg::MAX_LINE);
   localparam logic [2:0] MAX_DIG = 3'(csvp_pkg::DIGITS_PER_FIELD);

   logic [2:0]          comma_count_ff, comma_count_in;
   logic [2:0]          digit_count_ff, digit_count_in;
   csvp_pkg::field_type field_value_ff [csvp_pkg::NUM_FIELDS];
   csvp_pkg::field_type field_value_in [csvp_pkg::NUM_FIELDS];
   logic [4:0]          line_length_ff, line_length_in;
   logic                too_long_ff, too_long_in;
   logic                out_valid_ff, out_valid_in;
   csvp_pkg::record_type out_rec_ff, out_rec_in;

   logic                take, emit;
   csvp_pkg::field_type cur, acc;

   // a token is taken whenever the result register is free or draining
   assign tok_ready = !out_valid_ff || out_ready;
   assign take      = tok_valid && tok_ready;
   assign out_valid = out_valid_ff;
   assign out_rec   = out_rec_ff;

   assign cur = field_value_ff[comma_count_ff[1:0]];
   // v*10 + d, kept to 14 bits
   assign acc = csvp_pkg::DC_W'({cur, 3'b000} + {cur, 1'b0} + {10'd0, tok.digit});

   assign emit = (tok.kind == csvp_pkg::KIND_EOL) && (line_length_ff != 5'd0)
                 && !too_long_ff && (comma_count_ff >= 3'd3);

   always_comb begin
      comma_count_in = comma_count_ff;
      digit_count_in = digit_count_ff;
      line_length_in = line_length_ff;
      too_long_in    = too_long_ff;
      for (int k = 0; k < int'(csvp_pkg::NUM_FIELDS); k++) begin
         field_value_in[k] = field_value_ff[k];
      end
      out_valid_in = out_valid_ff && !out_ready;
      out_rec_in   = out_rec_ff;

      if (take) begin
         if (tok.kind == csvp_pkg::KIND_EOL) begin
            if (emit) begin
               out_valid_in           = 1'b1;
               out_rec_in.ac_red      = {1'b0, field_value_ff[0]} - {3'b000, ac_offset};
               out_rec_in.dc_red      = field_value_ff[1];
               out_rec_in.ac_infrared = {1'b0, field_value_ff[2]} - {3'b000, ac_offset};
               out_rec_in.dc_infrared = field_value_ff[3];
            end
            comma_count_in = 3'd0;
            digit_count_in = 3'd0;
            line_length_in = 5'd0;
            too_long_in    = 1'b0;
            for (int k = 0; k < int'(csvp_pkg::NUM_FIELDS); k++) begin
               field_value_in[k] = '0;
            end
         end else begin
            if (line_length_ff >= MAX_LEN) begin
               too_long_in = 1'b1;
            end else begin
               line_length_in = line_length_ff + 5'd1;
            end
            unique case (tok.kind)
               csvp_pkg::KIND_COMMA: begin
                  if (comma_count_ff < csvp_pkg::MAX_COMMAS) begin
                     comma_count_in = comma_count_ff + 3'd1;
                  end
                  digit_count_in = 3'd0;
               end
               csvp_pkg::KIND_DIGIT: begin
                  if ((comma_count_ff < csvp_pkg::MAX_COMMAS) && (digit_count_ff < MAX_DIG)) begin
                     field_value_in[comma_count_ff[1:0]] = acc;
                     digit_count_in = digit_count_ff + 3'd1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comma_count_ff <= 3'd0;
         digit_count_ff <= 3'd0;
         line_length_ff <= 5'd0;
         too_long_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         for (int k = 0; k < int'(csvp_pkg::NUM_FIELDS); k++) begin
            field_value_ff[k] <= '0;
         end
      end else begin
         comma_count_ff <= comma_count_in;
         digit_count_ff <= digit_count_in;
         line_length_ff <= line_length_in;
         too_long_ff    <= too_long_in;
         out_valid_ff   <= out_valid_in;
         for (int k = 0; k < int'(csvp_pkg::NUM_FIELDS); k++) begin
            field_value_ff[k] <= field_value_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      out_rec_ff <= out_rec_in;
   end

endmodule
`default_nettype wire

### design/csv_four_field_sample_parser.sv
// Channel  | dir | handshake              | payload
// req      | in  | req_tvalid/req_tready  | req_tdata[7:0]  character
// rsp      | out | rsp_tvalid/rsp_tready  | rsp_tdata[63:0] one record
// csr      | in  | csr_valid/csr_ready    | csr_data[11:0]  ac_offset
//
// One character per cycle unless req_tready is low; a record reaches rsp once
// its line end character has passed the queue slot, then the result register.
// The two-entry character queue takes two more characters while a record
// waits; req_tready drops only when the queue is full.
// Synchronous reset clears line state and sets ac_offset to 2048.
// Top level; depends on csvp_pkg, csvp_front and csvp_back.
`timescale 1ns / 1ps
`default_nettype none
module csv_four_field_sample_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] ch
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [14:0] ac_red, [28:15] dc_red,
                                         // [43:29] ac_infrared, [57:44] dc_infrared
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [11:0] csr_data
);

   logic [11:0]           ac_offset_ff, ac_offset_in;
   logic                  tok_valid, tok_ready;
   csvp_pkg::token_type   tok;
   csvp_pkg::record_type  rec;

   assign csr_ready    = 1'b1;
   assign ac_offset_in = (csr_valid && csr_ready) ? csr_data : ac_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ac_offset_ff <= csvp_pkg::OFFSET_RESET;
      end else begin
         ac_offset_ff <= ac_offset_in;
      end
   end

   csvp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_ch     (req_tdata),
      .tok_valid (tok_valid),
      .tok_ready (tok_ready),
      .tok       (tok)
   );

   csvp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (tok_valid),
      .tok_ready (tok_ready),
      .tok       (tok),
      .ac_offset (ac_offset_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (rec)
   );

   assign rsp_tdata = {6'd0, rec.dc_infrared, rec.ac_infrared, rec.dc_red, rec.ac_red};

endmodule
`default_nettype wire

### design/csvp_checker.sv
// Port-level checks for csv_four_field_sample_parser, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module csvp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata
);

   // no record can be pending straight after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("record pending after reset");

   // pad bits above the last field are always zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[63:58] == 6'd0))
      else $error("record padding not zero");

   // DC fields hold at most four decimal digits
   a_dc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[28:15] < 14'd10000) && (rsp_tdata[57:44] < 14'd10000)))
      else $error("DC field out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled record changed");

endmodule

bind csv_four_field_sample_parser csvp_checker u_csvp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
